// ===== rtl/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

  // Operation codes carried in the input tuser.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Field widths fixed by the item format.
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned PROBE_W = 4;
  // Signed search bounds span -1 .. 2047.
  localparam int unsigned BND_W   = CNT_W + 1;

  // Configuration register map (byte addresses).
  localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

  // Most probes a search over 1024 entries can make.
  localparam logic [PROBE_W-1:0] MAX_PROBES = 4'd11;

  // One search result.
  typedef struct packed {
    logic [PROBE_W-1:0] probe_count;
    logic [IDX_W-1:0]   position;
    logic               found;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted-table binary search.
// Input stream: one beat is a load (tuser = 0) that writes tdata's value at
// entry_index, or a search (tuser = 1) for the key in tdata's value field.
// A load gives no output beat; a search gives exactly one output beat with
// found, position and probe_count.
// The APB register entry_count (address 0) sets how many entries, from
// index 0, a search covers; write it only while the block is idle.
// A load is written in the cycle it is accepted. A search makes each probe
// as an address step, then a registered table read and compare, between a
// setup step and a hand-off step. One item is worked on at a time; the
// table's single read port and the dependence of each probe on the last
// make it so.
// The output beat sits in a register, so the next item is accepted while a
// finished result waits; a stalled receiver holds the search engine only
// when it has a second result ready.
// Reset clears control state and sets entry_count to 1024; table contents
// are undefined until loaded.
`default_nettype none

module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // entry_index[9:0], value[41:10], zero pad
  input  wire logic        s_axis_tuser,  // func
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // found[0], position[10:1], probe_count[14:11]
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import stbs_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CNT_W-1:0] entry_count_q;
  logic             res_valid, res_take;
  result_t          res;
  logic             out_valid_q;
  result_t          out_data_q;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= ENTRY_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_ENTRY_COUNT[2])) begin
      entry_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ADDR_ENTRY_COUNT[2]) ? 32'(entry_count_q) : '0;

  stbs_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  stbs_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser),
    .idx_i       (s_axis_tdata[IDX_W-1:0]),
    .value_i     (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
    .count_i     (entry_count_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  // Output register: refills when empty or drained in the same cycle.
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

endmodule

`default_nettype wire

// ===== rtl/stbs_table.sv =====
`default_nettype none

module stbs_table #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [stbs_pkg::VAL_W-1:0]   wdata_i,
  input  wire logic                         re_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic      [stbs_pkg::VAL_W-1:0]   rdata_o
);
  import stbs_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/stbs_ctrl.sv =====
`default_nettype none

module stbs_ctrl #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input item.
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         func_i,
  input  wire logic [stbs_pkg::IDX_W-1:0]   idx_i,
  input  wire logic [stbs_pkg::VAL_W-1:0]   value_i,
  input  wire logic [stbs_pkg::CNT_W-1:0]   count_i,
  // Result toward the output register.
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output stbs_pkg::result_t                 res_o,
  // Table ports.
  output logic                              we_o,
  output logic      [AW-1:0]                waddr_o,
  output logic      [stbs_pkg::VAL_W-1:0]   wdata_o,
  output logic                              re_o,
  output logic      [AW-1:0]                raddr_o,
  input  wire logic [stbs_pkg::VAL_W-1:0]   rdata_i
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic signed [BND_W-1:0]   low_q, low_d, high_q, high_d;
  logic [CNT_W-1:0]          mid_q, mid_d;
  logic [VAL_W-1:0]          key_q, key_d;
  logic [PROBE_W-1:0]        probes_q, probes_d;
  logic                      hit_q, hit_d;
  logic [IDX_W-1:0]          pos_q, pos_d;

  logic                      accept;
  logic [CNT_W-1:0]          count_sat;
  logic signed [BND_W-1:0]   high_init;
  logic [BND_W-1:0]          bound_sum;
  logic signed [BND_W-1:0]   mid_s;
  logic signed [BND_W-1:0]   low_n, high_n;
  logic signed [VAL_W-1:0]   entry_s, key_s;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // Loads go straight to the table while idle.
  assign we_o    = accept && (func_i == FUNC_LOAD) && (32'(idx_i) < DEPTH);
  assign waddr_o = AW'(idx_i);
  assign wdata_o = value_i;

  // Search span saturates at the table depth.
  assign count_sat = (32'(count_i) > DEPTH) ? CNT_W'(DEPTH) : count_i;
  assign high_init = $signed({1'b0, count_sat}) - BND_W'(1);

  // Midpoint of the bounds; both are non-negative while probing.
  assign bound_sum = BND_W'(low_q[CNT_W-1:0]) + BND_W'(high_q[CNT_W-1:0]);
  assign mid_d     = bound_sum[BND_W-1:1];
  assign re_o      = (state_q == ST_PROBE);
  assign raddr_o   = AW'(mid_d);

  // Bound update from the returned entry.
  assign entry_s = $signed(rdata_i);
  assign key_s   = $signed(key_q);
  assign mid_s   = $signed({1'b0, mid_q});

  always_comb begin
    low_n  = low_q;
    high_n = high_q;
    if (key_s > entry_s) begin
      low_n = mid_s + BND_W'(1);
    end else if (key_s < entry_s) begin
      high_n = mid_s - BND_W'(1);
    end
  end

  // Next-state logic.
  always_comb begin
    state_d  = state_q;
    low_d    = low_q;
    high_d   = high_q;
    key_d    = key_q;
    probes_d = probes_q;
    hit_d    = hit_q;
    pos_d    = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (func_i == FUNC_SEARCH)) begin
          key_d    = value_i;
          low_d    = '0;
          high_d   = high_init;
          probes_d = '0;
          hit_d    = 1'b0;
          pos_d    = '0;
          state_d  = (high_init < 0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        probes_d = probes_q + PROBE_W'(1);
        if (key_s == entry_s) begin
          hit_d   = 1'b1;
          pos_d   = mid_q[IDX_W-1:0];
          state_d = ST_DONE;
        end else begin
          low_d   = low_n;
          high_d  = high_n;
          state_d = (low_n <= high_n) ? ST_PROBE : ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      probes_q <= '0;
      hit_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      probes_q <= probes_d;
      hit_q    <= hit_d;
    end
  end

  // Search datapath registers.
  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    key_q  <= key_d;
    pos_q  <= pos_d;
    if (state_q == ST_PROBE) begin
      mid_q <= mid_d;
    end
  end

  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.found       = hit_q;
  assign res_o.position    = pos_q;
  assign res_o.probe_count = probes_q;

  // A probe is only issued while the bounds have not crossed.
  a_probe_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (low_q <= high_q))
    else $error("probe issued with crossed bounds");

  // No search over at most 1024 entries exceeds eleven probes.
  a_probe_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (probes_q <= MAX_PROBES))
    else $error("probe count above limit");

  // A hit needs at least one comparison.
  a_hit_probed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && hit_q) |-> (probes_q != '0))
    else $error("hit reported without a probe");

  // Every comparison is preceded by its memory read.
  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> $past(re_o))
    else $error("compare without a preceding read");

endmodule

`default_nettype wire

// ===== tb/sorted_table_binary_search_tb.sv =====
`default_nettype none

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int unsigned DEPTH        = 1024;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          INT_MIN      = 32'sh8000_0000;
  localparam int          INT_MAX      = 32'sh7fff_ffff;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // entry_index[9:0], value[41:10], zero pad
  logic        s_axis_tuser = 1'b0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // found[0], position[10:1], probe_count[14:11]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sorted_table_binary_search dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Mirror of the table and of the entry count register.
  int               table_mirror [DEPTH];
  logic [CNT_W-1:0] mirror_count = ENTRY_COUNT_RESET;

  // Search results still owed by the block, oldest first.
  result_t search_results_due [$];

  int mismatches     = 0;
  int cycles         = 0;
  int n_loads        = 0;
  int n_searches     = 0;
  int n_found        = 0;
  int n_count_writes = 0;
  int burst_left     = 0;
  int rx_hold_cycles = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Global watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding.", cycles,
               search_results_due.size());
      $display("sorted_table_binary_search_tb NOT OK");
      $finish;
    end
  end

  // Binary search over the mirrored table, probing mid = (low + high) / 2.
  function automatic result_t predict_search(input int key);
    int          lo;
    int          hi;
    int          mid;
    int unsigned span;
    result_t     r;
    r    = '0;
    span = (mirror_count > DEPTH) ? DEPTH : mirror_count;
    lo   = 0;
    hi   = int'(span) - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      r.probe_count = r.probe_count + PROBE_W'(1);
      if (key > table_mirror[mid]) begin
        lo = mid + 1;
      end else if (key < table_mirror[mid]) begin
        hi = mid - 1;
      end else begin
        r.found    = 1'b1;
        r.position = mid[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int pick_between(input longint lo, input longint hi);
    longint unsigned span;
    longint unsigned raw;
    span = longint'(hi - lo) + 1;
    raw  = {$urandom, $urandom};
    return int'(lo + longint'(raw % span));
  endfunction

  task automatic note_mismatch(input string what, input result_t exp, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (%s) at cycle %0d: expected found=%0b pos=%0d probes=%0d,",
               what, cycles, exp.found, exp.position, exp.probe_count);
      $display("  got found=%0b pos=%0d probes=%0d", got.found, got.position,
               got.probe_count);
    end
  endtask

  // Result side: check every accepted beat, then pick the next ready level.
  int rx_mode      = 0;
  int rx_mode_left = 0;
  always @(posedge clk_i) begin
    result_t got;
    result_t exp;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[14:0]);
        if (search_results_due.size() == 0) begin
          note_mismatch("result with nothing expected", '0, got);
        end else begin
          exp = search_results_due.pop_front();
          if (got.found !== exp.found) note_mismatch("found", exp, got);
          if (got.position !== exp.position) note_mismatch("position", exp, got);
          if (got.probe_count !== exp.probe_count) note_mismatch("probe_count", exp, got);
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(64, 256);
      end else begin
        rx_mode_left--;
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one beat, with burst gaps, and update the mirror once it is taken.
  task automatic send_beat(input logic func, input logic [IDX_W-1:0] idx, input int val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, idx};
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FUNC_SEARCH) begin
      search_results_due.push_back(predict_search(val));
      n_searches++;
      if (search_results_due[$].found) n_found++;
    end else begin
      table_mirror[idx] = val;
      n_loads++;
    end
  endtask

  task automatic load_entry(input int unsigned idx, input int val);
    send_beat(FUNC_LOAD, idx[IDX_W-1:0], val);
  endtask

  task automatic search_key(input int key);
    send_beat(FUNC_SEARCH, IDX_W'($urandom_range(0, DEPTH - 1)), key);
  endtask

  // Stop offering, wait for every owed result, then let the block settle.
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (search_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup phase, then access phase; only while idle.
  task automatic write_entry_count(input logic [CNT_W-1:0] cnt);
    drain_stream();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ENTRY_COUNT;
    pwdata  <= {{(32 - CNT_W){1'b0}}, cnt};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    mirror_count = cnt;
    n_count_writes++;
  endtask

  // Empty and one-entry tables, extremes, duplicates and an unsorted entry.
  task automatic test_small_tables();
    int vals [8] = '{INT_MIN, -5, -1, 0, 0, 7, 1000, INT_MAX};
    write_entry_count(11'd0);
    search_key(32'sh1234_5678);
    load_entry(0, INT_MIN);
    write_entry_count(11'd1);
    search_key(INT_MIN);
    search_key(INT_MAX);
    search_key(0);
    for (int i = 0; i < 8; i++) load_entry(i, vals[i]);
    write_entry_count(11'd8);
    search_key(INT_MIN);
    search_key(INT_MAX);
    search_key(0);
    search_key(-3);
    search_key(1001);
    search_key(-5);
    // Break the order and search past the misplaced entry.
    load_entry(3, 99);
    search_key(99);
    search_key(7);
  endtask

  // Fill the whole table with ascending values, some repeated.
  task automatic test_fill_table();
    longint v;
    v = longint'(INT_MIN) + $urandom_range(0, 1000);
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) v = longint'(INT_MIN);
      else if (i == DEPTH - 1) v = longint'(INT_MAX);
      else if ($urandom_range(0, 9) != 0) v = v + $urandom_range(1, 8_000_000);
      if (v > INT_MAX) v = longint'(INT_MAX);
      load_entry(i, int'(v));
    end
    // A count above the table size saturates to the full table.
    write_entry_count(11'd2047);
    search_key(table_mirror[0]);
    search_key(table_mirror[DEPTH - 1]);
    search_key(table_mirror[DEPTH / 2 - 1]);
    search_key(table_mirror[DEPTH / 2] + 1);
    write_entry_count(11'd1024);
    search_key(table_mirror[DEPTH - 1]);
    search_key(table_mirror[317]);
  endtask

  // Phases of random loads and searches over varied entry counts.
  task automatic test_random_items(input int phases, input int items_per_phase);
    logic [CNT_W-1:0] cnt;
    int unsigned      span;
    int unsigned      idx;
    longint           lo;
    longint           hi;
    int               key;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0:       cnt = 11'd1;
        1:       cnt = 11'd2;
        2:       cnt = 11'd1024;
        3:       cnt = 11'd2047;
        4:       cnt = 11'd0;
        5:       cnt = 11'd3;
        6:       cnt = CNT_W'($urandom_range(1025, 2046));
        default: cnt = CNT_W'($urandom_range(4, 1023));
      endcase
      write_entry_count(cnt);
      span = (cnt > DEPTH) ? DEPTH : cnt;
      for (int i = 0; i < items_per_phase; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          // Loads mostly keep the table sorted; a few break the order.
          idx = $urandom_range(0, DEPTH - 1);
          lo  = (idx == 0) ? longint'(INT_MIN) : longint'(table_mirror[idx - 1]);
          hi  = (idx == DEPTH - 1) ? longint'(INT_MAX) : longint'(table_mirror[idx + 1]);
          if ($urandom_range(0, 9) == 0 || lo > hi) load_entry(idx, $urandom);
          else load_entry(idx, pick_between(lo, hi));
        end else begin
          if (span == 0 || $urandom_range(0, 4) == 0) begin
            key = $urandom;
          end else begin
            key = table_mirror[$urandom_range(0, span - 1)];
            if ($urandom_range(0, 3) == 0) key = key + ($urandom_range(0, 1) ? 1 : -1);
          end
          search_key(key);
        end
      end
    end
  endtask

  // Stall the receiver for a long stretch while searches keep coming.
  task automatic test_backpressure();
    write_entry_count(11'd1024);
    rx_hold_cycles = 400;
    for (int i = 0; i < 24; i++) search_key(table_mirror[$urandom_range(0, DEPTH - 1)]);
    drain_stream();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_tables();
    test_fill_table();
    test_random_items(10, 40);
    test_backpressure();
    drain_stream();
    $display("Covered %0d loads and %0d searches (%0d hits) over %0d entry count settings,",
             n_loads, n_searches, n_found, n_count_writes);
    $display("including empty, single-entry and saturated tables and a long output stall.");
    if (mismatches == 0) begin
      $display("sorted_table_binary_search_tb OK");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("sorted_table_binary_search_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
